>>> hw/rtl/psme_pkg.sv
// Package with commands, states and arithmetic helpers of the packed symmetric matrix engine.
`timescale 1ns / 1ps
package psme_pkg;

    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_LOAD  = 3'd1,
        CMD_RANK1 = 3'd2,
        CMD_QUAD  = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_R1_W,
        ST_R1_T,
        ST_R1_RD,
        ST_R1_MUL,
        ST_R1_WB,
        ST_Q_RD,
        ST_Q_M1,
        ST_Q_M2,
        ST_Q_ACC,
        ST_Q_OUT,
        ST_C_RD,
        ST_C_OUT
    } state_t;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF)
        begin
            r = S32_MAX;
        end
        else if (x < -64'sh0000_0000_8000_0000)
        begin
            r = S32_MIN;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/packed_symmetric_matrix_engine.sv
// Top level of the packed symmetric matrix engine: sequencer, memories and datapath.
`timescale 1ns / 1ps
// Channel    | Direction | Handshake            | Payload
// command    | in        | start / busy         | cmd, row_index, col_index, operand
// config     | in        | cfg_valid/cfg_ready  | cfg_data (size_in_use)
// result     | out       | result_strobe        | result_value, last_of_run
// Write and load are taken in their accept cycle and never raise busy. A rank-one
// update keeps busy high through steps W, T, RD per column and MUL, WB per packed
// entry; a quadratic form through RD, then M1, M2, ACC per packed entry, then OUT;
// a column read through RD, OUT per element. The steps come from the single read
// port of the triangle memory and one multiplier shared over the steps of an entry.
// Reset clears the control state and sets the order to 16; the memories are not
// cleared. Config writes wait while busy. Results cannot be stalled: each shows for
// one cycle.
module packed_symmetric_matrix_engine #(
    parameter int MAX_ORDER = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          cmd,
    input  logic [3:0]          row_index,
    input  logic [3:0]          col_index,
    input  logic signed [31:0]  operand,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [4:0]          cfg_data,
    output logic                result_strobe,
    output logic signed [63:0]  result_value,
    output logic                last_of_run
);
    import psme_pkg::*;

    localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int NW = $clog2(MAX_ORDER + 1);

    // Memories.
    logic signed [31:0] tri_mem [DEPTH];
    logic signed [31:0] vec_mem [MAX_ORDER];

    state_t state_reg, state_next;
    logic [4:0] size_reg;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next;
    logic [AW-1:0] base_reg, base_next;
    logic signed [31:0] w_reg, w_next, t_reg, t_next, p_reg, p_next;
    logic signed [63:0] acc_reg, acc_next, prod_reg, prod_next;

    // Read ports, registered.
    logic [AW-1:0] tri_raddr, tri_waddr;
    logic [IW-1:0] vec_raddr;
    logic signed [31:0] tri_rdata, vec_rdata, tri_wdata, vec_wdata;
    logic tri_we, vec_we;
    logic [IW-1:0] vec_waddr;

    always_ff @(posedge clk)
    begin
        tri_rdata <= tri_mem[tri_raddr];
        vec_rdata <= vec_mem[vec_raddr];
        if (tri_we)
        begin
            tri_mem[tri_waddr] <= tri_wdata;
        end
        if (vec_we)
        begin
            vec_mem[vec_waddr] <= vec_wdata;
        end
    end

    // Effective order.
    logic [NW-1:0] n_eff;
    logic [IW-1:0] last_idx;
    always_comb
    begin
        if (size_reg == 5'd0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(size_reg) > MAX_ORDER)
        begin
            n_eff = NW'(MAX_ORDER);
        end
        else
        begin
            n_eff = NW'(size_reg);
        end
        last_idx = IW'(n_eff - NW'(1));
    end

    // Packed column base of an index.
    function automatic logic [AW-1:0] col_base(input logic [IW-1:0] c);
        logic [AW+IW:0] b;
        b = ((AW+IW+1)'(c) * ((AW+IW+1)'(c) + 1'b1)) >> 1;
        return AW'(b);
    endfunction

    logic [IW-1:0] row_c, col_c;
    assign row_c = IW'(row_index);
    assign col_c = IW'(col_index);

    assign busy = (state_reg != ST_IDLE);
    // The order must not change under a running command.
    assign cfg_ready = !busy;

    // Product of the current multiplier operands, shifted right 16.
    logic signed [31:0] ma, mb;
    logic signed [63:0] mprod;
    assign mprod = (64'(ma) * 64'(mb)) >>> 16;

    logic signed [63:0] addend, acc_sum;
    logic pos_ovf, neg_ovf;
    assign addend = (i_reg == j_reg) ? prod_reg : (prod_reg <<< 1);
    assign acc_sum = acc_reg + addend;
    assign pos_ovf = !acc_reg[63] && !addend[63] && acc_sum[63];
    assign neg_ovf = acc_reg[63] && addend[63] && !acc_sum[63];

    // Sequencer and datapath control.
    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        base_next = base_reg;
        w_next = w_reg;
        t_next = t_reg;
        p_next = p_reg;
        acc_next = acc_reg;
        prod_next = prod_reg;
        tri_raddr = base_reg + AW'(i_reg);
        vec_raddr = i_reg;
        tri_we = 1'b0;
        tri_waddr = base_reg + AW'(i_reg);
        tri_wdata = operand;
        vec_we = 1'b0;
        vec_waddr = col_c;
        vec_wdata = operand;
        ma = w_reg;
        mb = vec_rdata;
        result_strobe = 1'b0;
        result_value = acc_reg;
        last_of_run = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_WRITE:
                        begin
                            if (NW'(row_c) < n_eff && NW'(col_c) < n_eff && 32'(row_index) < MAX_ORDER
                                && 32'(col_index) < MAX_ORDER)
                            begin
                                tri_we = 1'b1;
                                tri_waddr = (row_c > col_c) ? col_base(row_c) + AW'(col_c)
                                                            : col_base(col_c) + AW'(row_c);
                            end
                        end
                        CMD_LOAD:
                        begin
                            if (NW'(col_c) < n_eff && 32'(col_index) < MAX_ORDER)
                            begin
                                vec_we = 1'b1;
                            end
                        end
                        CMD_RANK1:
                        begin
                            w_next = operand;
                            j_next = '0;
                            i_next = '0;
                            base_next = '0;
                            vec_raddr = '0;
                            state_next = ST_R1_W;
                        end
                        CMD_QUAD:
                        begin
                            acc_next = '0;
                            j_next = '0;
                            i_next = '0;
                            base_next = '0;
                            state_next = ST_Q_RD;
                        end
                        CMD_READ:
                        begin
                            if (NW'(col_c) < n_eff && 32'(col_index) < MAX_ORDER)
                            begin
                                j_next = col_c;
                                i_next = '0;
                                state_next = ST_C_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // Rank-one: v[j] is on the read port; form t.
            ST_R1_W:
            begin
                vec_raddr = j_reg;
                state_next = ST_R1_T;
            end
            ST_R1_T:
            begin
                ma = w_reg;
                mb = vec_rdata;
                t_next = sat32(mprod);
                state_next = ST_R1_RD;
            end
            ST_R1_RD:
            begin
                state_next = ST_R1_MUL;
            end
            ST_R1_MUL:
            begin
                ma = t_reg;
                mb = vec_rdata;
                prod_next = mprod;
                state_next = ST_R1_WB;
            end
            ST_R1_WB:
            begin
                tri_we = 1'b1;
                tri_wdata = sat32(64'(tri_rdata) + prod_reg);
                if (i_reg == j_reg)
                begin
                    if (j_reg == last_idx)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        base_next = base_reg + AW'(j_reg) + AW'(1);
                        j_next = j_reg + IW'(1);
                        i_next = '0;
                        vec_raddr = j_reg + IW'(1);
                        state_next = ST_R1_W;
                    end
                end
                else
                begin
                    i_next = i_reg + IW'(1);
                    tri_raddr = base_reg + AW'(i_reg) + AW'(1);
                    vec_raddr = i_reg + IW'(1);
                    state_next = ST_R1_MUL;
                end
            end
            // Quadratic form: S(i,j) and v[i] are read.
            ST_Q_RD:
            begin
                state_next = ST_Q_M1;
            end
            ST_Q_M1:
            begin
                ma = tri_rdata;
                mb = vec_rdata;
                p_next = sat32(mprod);
                vec_raddr = j_reg;
                state_next = ST_Q_M2;
            end
            ST_Q_M2:
            begin
                ma = p_reg;
                mb = vec_rdata;
                prod_next = mprod;
                state_next = ST_Q_ACC;
            end
            ST_Q_ACC:
            begin
                priority if (pos_ovf)
                begin
                    acc_next = 64'sh7FFF_FFFF_FFFF_FFFF;
                end
                else if (neg_ovf)
                begin
                    acc_next = 64'sh8000_0000_0000_0000;
                end
                else
                begin
                    acc_next = acc_sum;
                end
                if (i_reg == j_reg)
                begin
                    if (j_reg == last_idx)
                    begin
                        state_next = ST_Q_OUT;
                    end
                    else
                    begin
                        base_next = base_reg + AW'(j_reg) + AW'(1);
                        j_next = j_reg + IW'(1);
                        i_next = '0;
                        tri_raddr = base_reg + AW'(j_reg) + AW'(1);
                        vec_raddr = '0;
                        state_next = ST_Q_M1;
                    end
                end
                else
                begin
                    i_next = i_reg + IW'(1);
                    tri_raddr = base_reg + AW'(i_reg) + AW'(1);
                    vec_raddr = i_reg + IW'(1);
                    state_next = ST_Q_M1;
                end
            end
            ST_Q_OUT:
            begin
                result_strobe = 1'b1;
                result_value = acc_reg;
                last_of_run = 1'b1;
                state_next = ST_IDLE;
            end
            // Column read: element i of column j, mirrored below the diagonal.
            ST_C_RD:
            begin
                tri_raddr = (i_reg <= j_reg) ? col_base(j_reg) + AW'(i_reg)
                                             : col_base(i_reg) + AW'(j_reg);
                state_next = ST_C_OUT;
            end
            ST_C_OUT:
            begin
                result_strobe = 1'b1;
                result_value = 64'(tri_rdata);
                last_of_run = (i_reg == last_idx);
                if (i_reg == last_idx)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    i_next = i_reg + IW'(1);
                    state_next = ST_C_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers; the order comes out of reset as 16.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            size_reg <= 5'd16;
            acc_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg <= acc_next;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        j_reg <= j_next;
        base_reg <= base_next;
        w_reg <= w_next;
        t_reg <= t_next;
        p_reg <= p_next;
        prod_reg <= prod_next;
    end

endmodule
